/* sv/particle_pool_engine_core_defines.svh */
// Assertion macros used by the particle pool engine core.
`ifndef PARTICLE_POOL_ENGINE_CORE_DEFINES_SVH
`define PARTICLE_POOL_ENGINE_CORE_DEFINES_SVH

// Condition that must hold on every clock edge out of reset.
`define PPE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define PPE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/ppe_pkg.sv */
package ppe_pkg;

    // Default pool size, fixed field widths and the depth base offset.
    localparam int POOL_SIZE_DEF = 32;
    localparam int SLOT_W        = 6;
    localparam int DEPTH_W       = 17;
    localparam int DEPTH_BASE    = 25;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_SPAWN = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_DRAW  = 2'd2
    } cmd_t;

    // Result kinds.
    typedef enum logic [1:0] {
        RK_PLACED  = 2'd0,
        RK_DROPPED = 2'd1,
        RK_DRAW    = 2'd2
    } result_kind_t;

    // Register indexes of the configuration port.
    typedef enum logic [1:0] {
        REG_FRAMES0 = 2'd0,
        REG_FRAMES1 = 2'd1,
        REG_FRAMES2 = 2'd2,
        REG_FRAMES3 = 2'd3
    } reg_idx_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPAWN,
        ST_TICK_RD,
        ST_TICK_WR,
        ST_DRAW_RD,
        ST_DRAW_MUL,
        ST_DRAW_DIV,
        ST_DRAW_PUT
    } state_t;

    // One particle record as held in the pool memory.
    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] vel_x;
        logic [15:0] vel_y;
        logic [1:0]  kind;
        logic [15:0] age;
        logic [15:0] lifetime;
    } ppe_rec_t;

    // Write request into the pool memory.
    typedef struct packed {
        logic            en;
        logic [SLOT_W-1:0] addr;
        ppe_rec_t        data;
    } ppe_wr_t;

endpackage

/* sv/particle_pool_engine_core.sv */
// Particle pool engine.
// Input channel (in_valid/in_stall) carries one request: spawn, tick or draw.
// Output channel (out_valid/out_stall) carries results; last marks the final
// result of a request. A spawn gives one result, a tick none, and a draw one
// result per active slot from the lowest slot up (none if the pool is empty).
// Frame counts per particle type are written over the APB port, which is
// always ready, and are read directly by each draw, also one in progress.
// Steps: a spawn scans slots one per cycle. A tick reads every slot and
// writes each active one back. A draw reads every slot and, for each
// active one, goes through memory read, multiply, a wait on the divider for
// the frame index and the output load. A new request is taken once the
// previous one is done, even while its last result still waits in the
// output register.
// Reset clears all slots to inactive at once through per-slot active bits.
// While out_stall is high and a result is held, the output register holds,
// and the sequencer waits before loading the next result.
module particle_pool_engine_core
    import ppe_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // Request channel.
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          command,
    input  logic signed [15:0]  start_x,
    input  logic signed [15:0]  start_y,
    input  logic signed [15:0]  speed_x,
    input  logic signed [15:0]  speed_y,
    input  logic [1:0]          kind,
    input  logic [15:0]         lifetime,
    // Result channel.
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          result_kind,
    output logic [SLOT_W-1:0]   slot,
    output logic signed [11:0]  screen_x,
    output logic signed [11:0]  screen_y,
    output logic [1:0]          drawn_kind,
    output logic [7:0]          frame,
    output logic [DEPTH_W-1:0]  depth,
    output logic                last,
    // Configuration port.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

`include "particle_pool_engine_core_defines.svh"

    localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CW = $clog2(POOL_SIZE + 1);

    // Configuration registers.
    logic [7:0] frames0_reg, frames1_reg, frames2_reg, frames3_reg;
    logic       cfg_we;
    reg_idx_t   cfg_sel;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_sel = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames0_reg <= 8'd1;
            frames1_reg <= 8'd1;
            frames2_reg <= 8'd1;
            frames3_reg <= 8'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_sel)
                REG_FRAMES0: frames0_reg <= pwdata[7:0];
                REG_FRAMES1: frames1_reg <= pwdata[7:0];
                REG_FRAMES2: frames2_reg <= pwdata[7:0];
                REG_FRAMES3: frames3_reg <= pwdata[7:0];
                default:     frames0_reg <= frames0_reg;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (cfg_sel)
            REG_FRAMES0: prdata = {24'd0, frames0_reg};
            REG_FRAMES1: prdata = {24'd0, frames1_reg};
            REG_FRAMES2: prdata = {24'd0, frames2_reg};
            REG_FRAMES3: prdata = {24'd0, frames3_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // Sequencer and datapath state.
    state_t                 state_reg, state_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [POOL_SIZE-1:0]   live_reg, live_next;
    ppe_rec_t               spawn_reg, spawn_next;
    logic [SLOT_W-1:0]      hold_slot_reg, hold_slot_next;
    logic [11:0]            hold_x_reg, hold_x_next;
    logic [11:0]            hold_y_reg, hold_y_next;
    logic [1:0]             hold_kind_reg, hold_kind_next;
    logic [DEPTH_W-1:0]     hold_depth_reg, hold_depth_next;
    logic                   hold_last_reg, hold_last_next;

    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             rk_reg, rk_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [11:0]            sx_reg, sx_next;
    logic [11:0]            sy_reg, sy_next;
    logic [1:0]             dk_reg, dk_next;
    logic [7:0]             frame_reg, frame_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;
    logic                   last_reg, last_next;

    logic [AW-1:0]          cur;
    logic                   at_end;
    logic                   load_ok;
    logic                   higher_live;
    logic [7:0]             cur_frames;
    logic [16:0]            age_inc;
    ppe_wr_t                wr;
    ppe_rec_t               rd_data;
    ppe_rec_t               upd;
    logic                   div_start;
    logic                   div_done;
    logic [7:0]             div_quot;

    assign cur     = idx_reg[AW-1:0];
    assign at_end  = (idx_reg == CW'(POOL_SIZE));
    assign load_ok = !out_valid_reg || !out_stall;
    assign age_inc = {1'b0, rd_data.age} + 17'd1;

    // Any active slot above the current one decides the last flag of a draw.
    always_comb
    begin
        higher_live = 1'b0;
        for (int j = 0; j < POOL_SIZE; j++)
        begin
            if ((CW'(j) > idx_reg) && live_reg[j])
            begin
                higher_live = 1'b1;
            end
        end
    end

    // Frame count of the particle read from the pool.
    always_comb
    begin
        case (rd_data.kind)
            2'd0:    cur_frames = frames0_reg;
            2'd1:    cur_frames = frames1_reg;
            2'd2:    cur_frames = frames2_reg;
            default: cur_frames = frames3_reg;
        endcase
    end

    // Moved and aged record for a tick.
    always_comb
    begin
        upd       = rd_data;
        upd.pos_x = rd_data.pos_x + rd_data.vel_x;
        upd.pos_y = rd_data.pos_y + rd_data.vel_y;
        upd.age   = age_inc[15:0];
    end

    // Next state and outputs.
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        live_next       = live_reg;
        spawn_next      = spawn_reg;
        hold_slot_next  = hold_slot_reg;
        hold_x_next     = hold_x_reg;
        hold_y_next     = hold_y_reg;
        hold_kind_next  = hold_kind_reg;
        hold_depth_next = hold_depth_reg;
        hold_last_next  = hold_last_reg;
        out_valid_next  = out_valid_reg && out_stall;
        rk_next         = rk_reg;
        slot_next       = slot_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        dk_next         = dk_reg;
        frame_next      = frame_reg;
        depth_next      = depth_reg;
        last_next       = last_reg;
        in_stall        = 1'b1;
        wr              = '0;
        div_start       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    idx_next   = '0;
                    spawn_next = '{pos_x: start_x, pos_y: start_y, vel_x: speed_x,
                                   vel_y: speed_y, kind: kind, age: 16'd0,
                                   lifetime: lifetime};
                    case (command)
                        CMD_SPAWN: state_next = ST_SPAWN;
                        CMD_TICK:  state_next = ST_TICK_RD;
                        CMD_DRAW:  state_next = ST_DRAW_RD;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end

            // Spawn: look for the lowest inactive slot.
            ST_SPAWN:
            begin
                if (at_end || !live_reg[cur])
                begin
                    if (load_ok)
                    begin
                        out_valid_next = 1'b1;
                        sx_next        = '0;
                        sy_next        = '0;
                        dk_next        = '0;
                        frame_next     = '0;
                        depth_next     = '0;
                        last_next      = 1'b1;
                        state_next     = ST_IDLE;
                        if (at_end)
                        begin
                            rk_next   = RK_DROPPED;
                            slot_next = '0;
                        end
                        else
                        begin
                            rk_next        = RK_PLACED;
                            slot_next      = SLOT_W'(cur);
                            wr.en          = 1'b1;
                            wr.addr        = SLOT_W'(cur);
                            wr.data        = spawn_reg;
                            live_next[cur] = (spawn_reg.lifetime != 16'd0);
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            // Tick: read each slot, then write each active one back moved and aged.
            ST_TICK_RD:
            begin
                if (at_end)
                begin
                    state_next = ST_IDLE;
                end
                else if (live_reg[cur])
                begin
                    state_next = ST_TICK_WR;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            ST_TICK_WR:
            begin
                wr.en          = 1'b1;
                wr.addr        = SLOT_W'(cur);
                wr.data        = upd;
                live_next[cur] = (age_inc < {1'b0, rd_data.lifetime});
                idx_next       = idx_reg + CW'(1);
                state_next     = ST_TICK_RD;
            end

            // Draw: read each active slot and compute its frame.
            ST_DRAW_RD:
            begin
                if (at_end)
                begin
                    state_next = ST_IDLE;
                end
                else if (live_reg[cur])
                begin
                    state_next = ST_DRAW_MUL;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            ST_DRAW_MUL:
            begin
                div_start       = 1'b1;
                hold_slot_next  = SLOT_W'(cur);
                hold_x_next     = rd_data.pos_x[15:4];
                hold_y_next     = rd_data.pos_y[15:4];
                hold_kind_next  = rd_data.kind;
                hold_depth_next = DEPTH_W'(rd_data.age) + DEPTH_W'(DEPTH_BASE);
                hold_last_next  = !higher_live;
                state_next      = ST_DRAW_DIV;
            end

            ST_DRAW_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DRAW_PUT;
                end
            end

            ST_DRAW_PUT:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    rk_next        = RK_DRAW;
                    slot_next      = hold_slot_reg;
                    sx_next        = hold_x_reg;
                    sy_next        = hold_y_reg;
                    dk_next        = hold_kind_reg;
                    frame_next     = div_quot;
                    depth_next     = hold_depth_reg;
                    last_next      = hold_last_reg;
                    idx_next       = idx_reg + CW'(1);
                    state_next     = ST_DRAW_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        spawn_reg      <= spawn_next;
        hold_slot_reg  <= hold_slot_next;
        hold_x_reg     <= hold_x_next;
        hold_y_reg     <= hold_y_next;
        hold_kind_reg  <= hold_kind_next;
        hold_depth_reg <= hold_depth_next;
        hold_last_reg  <= hold_last_next;
        rk_reg         <= rk_next;
        slot_reg       <= slot_next;
        sx_reg         <= sx_next;
        sy_reg         <= sy_next;
        dk_reg         <= dk_next;
        frame_reg      <= frame_next;
        depth_reg      <= depth_next;
        last_reg       <= last_next;
    end

    // Pool memory.
    ppe_store #(
        .POOL_SIZE (POOL_SIZE)
    ) u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (cur),
        .rd_data (rd_data)
    );

    // Frame index divider.
    ppe_frame_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .age      (rd_data.age),
        .count    (cur_frames),
        .lifetime (rd_data.lifetime),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Result ports.
    assign out_valid   = out_valid_reg;
    assign result_kind = rk_reg;
    assign slot        = slot_reg;
    assign screen_x    = $signed(sx_reg);
    assign screen_y    = $signed(sy_reg);
    assign drawn_kind  = dk_reg;
    assign frame       = frame_reg;
    assign depth       = depth_reg;
    assign last        = last_reg;

    // Checks on the sequencer.
    `PPE_ASSERT_IMPL(a_wr_state, wr.en,
        (state_reg == ST_TICK_WR) || (state_reg == ST_SPAWN), "pool write outside write state")
    `PPE_ASSERT_IMPL(a_div_state, div_done,
        state_reg == ST_DRAW_DIV, "divider finished outside its wait state")
    `PPE_ASSERT_NEXT(a_spawn_done, (state_reg == ST_SPAWN) && out_valid_next && load_ok,
        state_reg == ST_IDLE, "spawn did not return to idle after its result")
    `PPE_ASSERT_ALWAYS(a_idx_range, idx_reg <= CW'(POOL_SIZE), "slot counter beyond pool")

endmodule

/* sv/ppe_store.sv */
module ppe_store
    import ppe_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEF
)
(
    input  logic     clk,
    input  ppe_wr_t  wr,
    input  logic [((POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1)-1:0] rd_addr,
    output ppe_rec_t rd_data
);

    localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

    ppe_rec_t mem [POOL_SIZE];
    ppe_rec_t rd_data_reg;

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/ppe_frame_div.sv */
module ppe_frame_div
    import ppe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] age,
    input  logic [7:0]  count,
    input  logic [15:0] lifetime,
    output logic        done,
    output logic [7:0]  quotient
);

    // The quotient is known to fit eight bits because age < lifetime,
    // so the top sixteen product bits already sit below the divisor.
    logic        mul_pend_reg, mul_pend_next;
    logic        done_reg, done_next;
    logic [3:0]  step_reg, step_next;
    logic [23:0] prod_reg, prod_next;
    logic [15:0] div_reg, div_next;
    logic [15:0] rem_reg, rem_next;
    logic [7:0]  low_reg, low_next;
    logic [7:0]  q_reg, q_next;
    logic [16:0] trial;
    logic        ge;

    always_comb
    begin
        mul_pend_next = 1'b0;
        done_next     = 1'b0;
        step_next     = step_reg;
        prod_next     = prod_reg;
        div_next      = div_reg;
        rem_next      = rem_reg;
        low_next      = low_reg;
        q_next        = q_reg;
        trial         = {rem_reg, low_reg[7]};
        ge            = (trial >= {1'b0, div_reg});

        if (start)
        begin
            // Multiply cycle.
            prod_next     = age * count;
            div_next      = lifetime;
            mul_pend_next = 1'b1;
        end
        else if (mul_pend_reg)
        begin
            rem_next  = prod_reg[23:8];
            low_next  = prod_reg[7:0];
            step_next = 4'd8;
        end
        else if (step_reg != 4'd0)
        begin
            // One restoring step per cycle.
            rem_next  = ge ? 16'(trial - {1'b0, div_reg}) : trial[15:0];
            q_next    = {q_reg[6:0], ge};
            low_next  = {low_reg[6:0], 1'b0};
            step_next = step_reg - 4'd1;
            done_next = (step_reg == 4'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_pend_reg <= 1'b0;
            done_reg     <= 1'b0;
            step_reg     <= 4'd0;
        end
        else
        begin
            mul_pend_reg <= mul_pend_next;
            done_reg     <= done_next;
            step_reg     <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        q_reg    <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
